### hw/rtl/gihe_pkg.sv
// Shared types, constants and tables of the GNSS/IMU heading estimator.
`timescale 1ns / 1ps
`default_nettype none
package gihe_pkg;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PX, ST_PY, ST_PD, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQRT,
		ST_DM, ST_DV0, ST_DIV, ST_SPD, ST_CI, ST_CORD, ST_HA, ST_HM, ST_HC,
		ST_IM0, ST_IM1, ST_IM2, ST_IM3, ST_IM4, ST_IM5, ST_IM6, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		REG_REF_LAT, REG_REF_LON, REG_LAT_SCALE, REG_LON_SCALE,
		REG_START_YAW, REG_SPEED_THRESHOLD, REG_RATE_DEADBAND
	} reg_idx_t;

	typedef struct packed {
		logic signed [30:0] ref_lat;
		logic signed [31:0] ref_lon;
		logic [23:0]        lat_scale;
		logic [23:0]        lon_scale;
		logic signed [15:0] start_yaw;
		logic [16:0]        speed_threshold;
		logic [13:0]        rate_deadband;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic signed [15:0] value;
	} yaw_load_t;

	localparam int unsigned ADDR_W = 5;
	localparam logic [23:0] LAT_SCALE_RST = 24'd728417;
	localparam logic [23:0] LON_SCALE_RST = 24'd729608;
	localparam logic [16:0] SPEED_THR_RST = 17'd800;
	localparam logic [13:0] DEADBAND_RST  = 14'd500;
	localparam logic signed [15:0] YAW_LIMIT = 16'sd18000;
	localparam logic signed [17:0] YAW_TURN  = 18'sd36000;
	localparam logic [19:0] SPEED_MAX = 20'd1000000;
	localparam logic [28:0] RATE_TURN_K = 29'd293589050;
	localparam logic [16:0] RATE_MAX = 17'd131071;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/gihe_in_if.sv
// Input channel: one GNSS fix or IMU sample word.
`timescale 1ns / 1ps
`default_nettype none
interface gihe_in_if #(parameter int TIME_BITS = 40);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic signed [30:0]   latitude;
	logic signed [31:0]   longitude;
	logic [TIME_BITS-1:0] time_us;
	logic signed [17:0]   rate_in;

	modport source (output valid, func, latitude, longitude, time_us, rate_in, input ready);
	modport sink (input valid, func, latitude, longitude, time_us, rate_in, output ready);
endinterface
`default_nettype wire

### hw/rtl/gihe_out_if.sv
// Output channel: one pose result word.
`timescale 1ns / 1ps
`default_nettype none
interface gihe_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_mm;
	logic signed [31:0] y_mm;
	logic [19:0]        speed;
	logic signed [15:0] yaw_cdeg;
	logic signed [17:0] yaw_rate_out;
	logic               valid_res;

	modport source (output valid, x_mm, y_mm, speed, yaw_cdeg, yaw_rate_out, valid_res,
		input ready);
	modport sink (input valid, x_mm, y_mm, speed, yaw_cdeg, yaw_rate_out, valid_res,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/gnss_imu_heading_estimator.sv
// Top level of the GNSS/IMU heading estimator: sequencer and shared datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word yields one pose result word. A GNSS fix maps to local
// millimetres, then takes a 32-step bit-serial square root, a 20-step divide and,
// when the speed exceeds the threshold, CORDIC_STEPS CORDIC iterations; the
// divide is skipped when the speed saturates or is 0, the CORDIC when the speed
// stays at or below the threshold; a first fix goes to the result after mapping.
// All products go through one registered 34x34 multiplier. The block takes one
// word at a time; the result sits in an output register while the next word is
// accepted.
module gnss_imu_heading_estimator #(
	parameter int CORDIC_STEPS = 16,
	parameter int TIME_BITS    = 40
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	gihe_in_if.sink                          sample,
	gihe_out_if.source                       result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gihe_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	localparam int CW = 37;

	gihe_pkg::cfg_t      cfg;
	gihe_pkg::yaw_load_t yaw_load;
	gihe_pkg::state_t    st_q, st_d;

	gihe_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg, .yaw_load
	);

	logic                 func_q;
	logic signed [30:0]   lat_q;
	logic signed [31:0]   lon_q;
	logic [TIME_BITS-1:0] t_q;
	logic signed [17:0]   rate_q;

	logic signed [33:0]   mul_a, mul_b;
	logic signed [67:0]   mp_q;

	logic signed [31:0]   x_new_q, last_x_q, last_y_q;
	logic [TIME_BITS-1:0] last_fix_q, last_imu_q, dt_q;
	logic                 gnss_seen_q, imu_seen_q;
	logic signed [15:0]   held_yaw_q;
	logic [19:0]          held_speed_q;
	logic signed [17:0]   held_rate_q;

	logic signed [32:0]   dx_q, dy_q;
	logic [31:0]          ax_q, ay_q;
	logic                 shr_q;
	logic [63:0]          acc_q, v_q, res_q, bit_q;
	logic [19:0]          nlo_q, quo_q, sp_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [4:0]           cnt_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [31:0]          z_q;
	logic signed [32:0]   a_q;
	logic                 neg_q;
	logic [16:0]          rmag_q;
	logic                 rneg_q;
	logic [31:0]          lo_q;
	logic [56:0]          mag_q;

	logic                 res_valid_q;

	// combinational helpers
	logic signed [32:0]   dlon, dx_n, dy_n;
	logic signed [31:0]   dlat, y_new;
	logic [32:0]          ax_n, ay_n, dlen;
	logic                 big;
	logic [63:0]          dt64, numh, sq_try;
	logic [39:0]          dtc;
	logic [52:0]          num;
	logic [TIME_BITS:0]   r2;
	logic                 ge;
	logic [19:0]          quo_n;
	logic signed [CW-1:0] xs, ys;
	logic [31:0]          abs_a;
	logic [63:0]          c_full;
	logic signed [17:0]   cs, ysum;
	logic signed [18:0]   nr;
	logic signed [17:0]   rr;
	logic [16:0]          rmag_n;
	logic [31:0]          tz;
	logic [63:0]          m_im;
	logic                 fin_go;

	function automatic logic signed [31:0] to_mm(input logic signed [67:0] p);
		logic signed [67:0] q;
		q = (p + 68'sd32768) >>> 16;
		if (q > 68'sd2147483647) q = 68'sd2147483647;
		if (q < -68'sd2147483648) q = -68'sd2147483648;
		return q[31:0];
	endfunction

	assign dlon  = $signed({lon_q[31], lon_q}) - $signed({cfg.ref_lon[31], cfg.ref_lon});
	assign dlat  = $signed({lat_q[30], lat_q}) - $signed({cfg.ref_lat[30], cfg.ref_lat});
	assign y_new = to_mm(mp_q);
	assign dx_n  = $signed({x_new_q[31], x_new_q}) - $signed({last_x_q[31], last_x_q});
	assign dy_n  = $signed({y_new[31], y_new}) - $signed({last_y_q[31], last_y_q});
	assign ax_n  = dx_n[32] ? 33'(-dx_n) : 33'(dx_n);
	assign ay_n  = dy_n[32] ? 33'(-dy_n) : 33'(dy_n);
	assign big   = ax_n[32] | ax_n[31] | ay_n[32] | ay_n[31];
	assign sq_try = res_q + bit_q;
	assign dlen  = shr_q ? {res_q[30:0], 2'b00} : {1'b0, res_q[31:0]};
	assign num   = mp_q[52:0];
	assign numh  = 64'(num[52:20]);
	assign dt64  = 64'(dt_q);
	assign dtc   = (dt64 > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : dt64[39:0];
	assign r2    = {rem_q, nlo_q[19]};
	assign ge    = r2 >= {1'b0, dt_q};
	assign quo_n = {quo_q[18:0], ge};
	assign xs    = cx_q >>> cnt_q;
	assign ys    = cy_q >>> cnt_q;
	assign abs_a = a_q[32] ? 32'(-a_q) : 32'(a_q);
	assign c_full = mp_q[63:0] + 64'h8000_0000;
	assign cs    = neg_q ? -18'(c_full[47:32]) : 18'(c_full[47:32]);
	assign nr    = -$signed({rate_q[17], rate_q});
	assign rr    = (nr > 19'sd131071) ? $signed({1'b0, gihe_pkg::RATE_MAX}) : nr[17:0];
	assign rmag_n = rr[17] ? 17'(-rr) : 17'(rr);
	assign m_im  = mp_q[63:0] + 64'(lo_q);
	assign tz    = rneg_q ? 32'(-m_im[31:0]) : m_im[31:0];
	assign fin_go = !res_valid_q || result.ready;

	always_comb begin
		ysum = (func_q ? 18'(held_yaw_q) : 18'sd0) + cs;
		if (ysum > 18'(gihe_pkg::YAW_LIMIT)) ysum = ysum - gihe_pkg::YAW_TURN;
		if (ysum < -18'(gihe_pkg::YAW_LIMIT)) ysum = ysum + gihe_pkg::YAW_TURN;
	end

	assign sample.ready = (st_q == gihe_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= gihe_pkg::ST_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d  = st_q;
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			gihe_pkg::ST_IDLE: if (sample.valid) begin
				st_d = sample.func ? gihe_pkg::ST_IM0 : gihe_pkg::ST_PX;
			end
			gihe_pkg::ST_PX: begin
				mul_a = 34'(dlon);
				mul_b = $signed({10'd0, cfg.lon_scale});
				st_d  = gihe_pkg::ST_PY;
			end
			gihe_pkg::ST_PY: begin
				mul_a = 34'(dlat);
				mul_b = $signed({10'd0, cfg.lat_scale});
				st_d  = gihe_pkg::ST_PD;
			end
			gihe_pkg::ST_PD: st_d = gnss_seen_q ? gihe_pkg::ST_SQ0 : gihe_pkg::ST_FIN;
			gihe_pkg::ST_SQ0: begin
				mul_a = $signed({2'b00, ax_q});
				mul_b = $signed({2'b00, ax_q});
				st_d  = gihe_pkg::ST_SQ1;
			end
			gihe_pkg::ST_SQ1: begin
				mul_a = $signed({2'b00, ay_q});
				mul_b = $signed({2'b00, ay_q});
				st_d  = gihe_pkg::ST_SQ2;
			end
			gihe_pkg::ST_SQ2: st_d = gihe_pkg::ST_SQRT;
			gihe_pkg::ST_SQRT: if (bit_q[0]) st_d = gihe_pkg::ST_DM;
			gihe_pkg::ST_DM: begin
				mul_a = $signed({1'b0, dlen});
				mul_b = $signed({14'd0, gihe_pkg::SPEED_MAX});
				st_d  = gihe_pkg::ST_DV0;
			end
			gihe_pkg::ST_DV0: begin
				if (num == '0 || numh >= dt64) st_d = gihe_pkg::ST_SPD;
				else                           st_d = gihe_pkg::ST_DIV;
			end
			gihe_pkg::ST_DIV: if (cnt_q == '0) st_d = gihe_pkg::ST_SPD;
			gihe_pkg::ST_SPD: begin
				st_d = (sp_q > {3'd0, cfg.speed_threshold}) ? gihe_pkg::ST_CI
					: gihe_pkg::ST_FIN;
			end
			gihe_pkg::ST_CI: st_d = gihe_pkg::ST_CORD;
			gihe_pkg::ST_CORD: if (cnt_q == 5'(CORDIC_STEPS - 1)) st_d = gihe_pkg::ST_HA;
			gihe_pkg::ST_HA: st_d = gihe_pkg::ST_HM;
			gihe_pkg::ST_HM: begin
				mul_a = $signed({2'b00, abs_a});
				mul_b = 34'sd36000;
				st_d  = gihe_pkg::ST_HC;
			end
			gihe_pkg::ST_HC: st_d = gihe_pkg::ST_FIN;
			gihe_pkg::ST_IM0: st_d = gihe_pkg::ST_IM1;
			gihe_pkg::ST_IM1: begin
				mul_a = $signed({17'd0, rmag_q});
				mul_b = $signed({14'd0, dtc[19:0]});
				st_d  = gihe_pkg::ST_IM2;
			end
			gihe_pkg::ST_IM2: begin
				mul_a = $signed({17'd0, rmag_q});
				mul_b = $signed({14'd0, dtc[39:20]});
				st_d  = gihe_pkg::ST_IM3;
			end
			gihe_pkg::ST_IM3: st_d = gihe_pkg::ST_IM4;
			gihe_pkg::ST_IM4: begin
				mul_a = $signed({2'b00, mag_q[31:0]});
				mul_b = $signed({5'd0, gihe_pkg::RATE_TURN_K});
				st_d  = gihe_pkg::ST_IM5;
			end
			gihe_pkg::ST_IM5: begin
				mul_a = $signed({9'd0, mag_q[56:32]});
				mul_b = $signed({5'd0, gihe_pkg::RATE_TURN_K});
				st_d  = gihe_pkg::ST_IM6;
			end
			gihe_pkg::ST_IM6: st_d = gihe_pkg::ST_HM;
			gihe_pkg::ST_FIN: if (fin_go) st_d = gihe_pkg::ST_IDLE;
			default: st_d = gihe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		mp_q <= mul_a * mul_b;
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (st_q)
			gihe_pkg::ST_IDLE: if (sample.valid) begin
				func_q <= sample.func;
				lat_q  <= sample.latitude;
				lon_q  <= sample.longitude;
				t_q    <= sample.time_us;
				rate_q <= sample.rate_in;
			end
			gihe_pkg::ST_PY: x_new_q <= to_mm(mp_q);
			gihe_pkg::ST_PD: begin
				dx_q  <= dx_n;
				dy_q  <= dy_n;
				shr_q <= big;
				ax_q  <= big ? 32'(ax_n >> 2) : ax_n[31:0];
				ay_q  <= big ? 32'(ay_n >> 2) : ay_n[31:0];
				dt_q  <= t_q - last_fix_q;
			end
			gihe_pkg::ST_SQ1: acc_q <= mp_q[63:0];
			gihe_pkg::ST_SQ2: begin
				v_q   <= acc_q + mp_q[63:0];
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			gihe_pkg::ST_SQRT: begin
				if (v_q >= sq_try) begin
					v_q   <= v_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			gihe_pkg::ST_DV0: begin
				if (num == '0) sp_q <= '0;
				else if (numh >= dt64) sp_q <= gihe_pkg::SPEED_MAX;
				rem_q <= numh[TIME_BITS-1:0];
				nlo_q <= num[19:0];
				quo_q <= '0;
				cnt_q <= 5'd19;
			end
			gihe_pkg::ST_DIV: begin
				rem_q <= ge ? TIME_BITS'(r2 - {1'b0, dt_q}) : r2[TIME_BITS-1:0];
				nlo_q <= {nlo_q[18:0], 1'b0};
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				sp_q  <= (quo_n > gihe_pkg::SPEED_MAX) ? gihe_pkg::SPEED_MAX : quo_n;
			end
			gihe_pkg::ST_CI: begin
				if (dx_q[32]) begin
					cx_q <= -CW'(dx_q);
					cy_q <= -CW'(dy_q);
					z_q  <= 32'h8000_0000;
				end else begin
					cx_q <= CW'(dx_q);
					cy_q <= CW'(dy_q);
					z_q  <= '0;
				end
				cnt_q <= '0;
			end
			gihe_pkg::ST_CORD: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + gihe_pkg::atan_turn(cnt_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - gihe_pkg::atan_turn(cnt_q);
				end
				cnt_q <= cnt_q + 5'd1;
			end
			gihe_pkg::ST_HA: a_q <= -$signed({z_q[31], z_q});
			gihe_pkg::ST_HM: neg_q <= a_q[32];
			gihe_pkg::ST_IM0: begin
				rmag_q <= (rmag_n < {3'd0, cfg.rate_deadband}) ? 17'd0 : rmag_n;
				rneg_q <= rr[17] && !(rmag_n < {3'd0, cfg.rate_deadband});
				dt_q   <= imu_seen_q ? (t_q - last_imu_q) : '0;
			end
			gihe_pkg::ST_IM2: acc_q <= mp_q[63:0];
			gihe_pkg::ST_IM3: mag_q <= 57'(acc_q + {mp_q[43:0], 20'd0});
			gihe_pkg::ST_IM5: lo_q <= c_full[63:32];
			gihe_pkg::ST_IM6: a_q <= $signed({tz[31], tz});
			default: ;
		endcase
	end

	// pose state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_fix_q   <= '0;
			last_imu_q   <= '0;
			gnss_seen_q  <= 1'b0;
			imu_seen_q   <= 1'b0;
			held_yaw_q   <= '0;
			held_speed_q <= '0;
			held_rate_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (st_q == gihe_pkg::ST_FIN && fin_go) res_valid_q <= 1'b1;
			else if (result.ready)                 res_valid_q <= 1'b0;
			unique case (st_q)
				gihe_pkg::ST_PD: begin
					if (!gnss_seen_q) held_speed_q <= '0;
					gnss_seen_q <= 1'b1;
					last_x_q    <= x_new_q;
					last_y_q    <= y_new;
					last_fix_q  <= t_q;
				end
				gihe_pkg::ST_SPD: held_speed_q <= sp_q;
				gihe_pkg::ST_HC: if (!yaw_load.load) held_yaw_q <= ysum[15:0];
				gihe_pkg::ST_IM0: begin
					held_rate_q <= (rmag_n < {3'd0, cfg.rate_deadband}) ? 18'sd0 : rr;
					imu_seen_q  <= 1'b1;
					last_imu_q  <= t_q;
				end
				default: ;
			endcase
			if (yaw_load.load) held_yaw_q <= yaw_load.value;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == gihe_pkg::ST_FIN && fin_go) begin
			result.x_mm         <= last_x_q;
			result.y_mm         <= last_y_q;
			result.speed        <= held_speed_q;
			result.yaw_cdeg     <= held_yaw_q;
			result.yaw_rate_out <= held_rate_q;
			result.valid_res    <= gnss_seen_q && imu_seen_q;
		end
	end

	assign result.valid = res_valid_q;
endmodule
`default_nettype wire

### hw/rtl/gihe_regs.sv
// APB configuration register file of the heading estimator.
`timescale 1ns / 1ps
`default_nettype none
module gihe_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gihe_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output gihe_pkg::cfg_t                    cfg,
	output gihe_pkg::yaw_load_t               yaw_load
);
	gihe_pkg::cfg_t     cfg_q;
	logic               we;
	logic signed [15:0] yaw_w;
	gihe_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign we     = psel && penable && pwrite;
	assign idx    = gihe_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_comb begin
		yaw_w = signed'(pwdata[15:0]);
		if (yaw_w > gihe_pkg::YAW_LIMIT) yaw_w = gihe_pkg::YAW_LIMIT;
		if (yaw_w < -gihe_pkg::YAW_LIMIT) yaw_w = -gihe_pkg::YAW_LIMIT;
		yaw_load.load  = we && (paddr[4:2] == 3'(gihe_pkg::REG_START_YAW));
		yaw_load.value = yaw_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_lat         <= '0;
			cfg_q.ref_lon         <= '0;
			cfg_q.lat_scale       <= gihe_pkg::LAT_SCALE_RST;
			cfg_q.lon_scale       <= gihe_pkg::LON_SCALE_RST;
			cfg_q.start_yaw       <= '0;
			cfg_q.speed_threshold <= gihe_pkg::SPEED_THR_RST;
			cfg_q.rate_deadband   <= gihe_pkg::DEADBAND_RST;
		end else if (we) begin
			unique case (idx)
				gihe_pkg::REG_REF_LAT:         cfg_q.ref_lat <= signed'(pwdata[30:0]);
				gihe_pkg::REG_REF_LON:         cfg_q.ref_lon <= signed'(pwdata);
				gihe_pkg::REG_LAT_SCALE:       cfg_q.lat_scale <= pwdata[23:0];
				gihe_pkg::REG_LON_SCALE:       cfg_q.lon_scale <= pwdata[23:0];
				gihe_pkg::REG_START_YAW:       cfg_q.start_yaw <= yaw_w;
				gihe_pkg::REG_SPEED_THRESHOLD: cfg_q.speed_threshold <= pwdata[16:0];
				gihe_pkg::REG_RATE_DEADBAND:   cfg_q.rate_deadband <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gihe_pkg::REG_REF_LAT:         prdata = {1'b0, cfg_q.ref_lat};
			gihe_pkg::REG_REF_LON:         prdata = cfg_q.ref_lon;
			gihe_pkg::REG_LAT_SCALE:       prdata = {8'd0, cfg_q.lat_scale};
			gihe_pkg::REG_LON_SCALE:       prdata = {8'd0, cfg_q.lon_scale};
			gihe_pkg::REG_START_YAW:       prdata = {16'd0, cfg_q.start_yaw};
			gihe_pkg::REG_SPEED_THRESHOLD: prdata = {15'd0, cfg_q.speed_threshold};
			gihe_pkg::REG_RATE_DEADBAND:   prdata = {18'd0, cfg_q.rate_deadband};
			default:                       prdata = '0;
		endcase
	end
endmodule
`default_nettype wire
